// ===== src/m3ws_pkg.sv =====
// ----------------------------------------------------------------------------
// m3ws_pkg
// Shared constants and types for the 3x3 window sum locator.
// ----------------------------------------------------------------------------
package m3ws_pkg;

  localparam int MAX_COLS   = 64;
  localparam int ROW_LIMIT  = 64;
  localparam int VALUE_BITS = 16;
  localparam int SUM_BITS   = 20;
  localparam int POS_BITS   = 6;
  localparam int SIZE_BITS  = 7;
  localparam int COL_BITS   = $clog2(MAX_COLS);
  localparam int ROW_BITS   = $clog2(ROW_LIMIT);
  localparam int CFG_IDX_BITS = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_COLS = 1'b1;

  typedef logic signed [VALUE_BITS-1:0] cell_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic [POS_BITS-1:0]          pos_t;
  typedef logic [SIZE_BITS-1:0]         size_t;

endpackage

// ===== src/m3ws_if.sv =====
// ----------------------------------------------------------------------------
// m3ws_if
// Valid/ready channel interfaces for cells in and locator results out.
// ----------------------------------------------------------------------------
interface m3ws_in_if;
  logic               valid;
  logic               ready;
  m3ws_pkg::cell_t    cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface m3ws_out_if;
  logic               valid;
  logic               ready;
  m3ws_pkg::sum_t     best_sum;
  m3ws_pkg::pos_t     center_row;
  m3ws_pkg::pos_t     center_col;
  logic               found;

  modport source (output valid, output best_sum, output center_row,
                  output center_col, output found, input ready);
  modport sink   (input valid, input best_sum, input center_row,
                  input center_col, input found, output ready);
endinterface

// ===== src/m3ws_ram.sv =====
// ----------------------------------------------------------------------------
// m3ws_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module m3ws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/max_3x3_window_sum_locator_unit.sv =====
// ----------------------------------------------------------------------------
// max_3x3_window_sum_locator_unit
// Streams grid cells in raster order and reports the 3x3 area with the
// largest sum once per frame.
// ----------------------------------------------------------------------------
// The block takes one cell per clock and finishes each cell in that same
// cycle; the only storage in the loop is the window, the counters and one
// 64 x 32 RAM that holds both previous rows for each column. The RAM is read
// ahead, at the column the next cell will use, with a one-entry
// bypass for a column written in the cycle before. The result of a frame
// appears in the output register on the cycle after the last cell. Input is
// held off only when a frame's last cell arrives while the previous frame's
// result has not yet been taken; all other cells keep flowing meanwhile.
// Line store entries read as zero until first written, tracked by one valid
// flip-flop per column, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module max_3x3_window_sum_locator_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  m3ws_in_if.sink                              in_ch,
  m3ws_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [m3ws_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [m3ws_pkg::SIZE_BITS-1:0]       cfg_data
);

  localparam int CB = m3ws_pkg::COL_BITS;
  localparam int RB = m3ws_pkg::ROW_BITS;
  localparam int VB = m3ws_pkg::VALUE_BITS;
  localparam int SB = m3ws_pkg::SIZE_BITS;
  localparam int WB = 2 * VB;
  localparam int MAX_COLS_W = m3ws_pkg::MAX_COLS;

  // Configuration
  m3ws_pkg::size_t grid_rows_r, grid_cols_r;
  m3ws_pkg::size_t rows_eff, cols_eff;

  // Counters and running best
  logic [CB-1:0]   col_r, col_nxt;
  logic [RB-1:0]   row_r, row_nxt;
  m3ws_pkg::sum_t  best_r, best_nxt;
  m3ws_pkg::pos_t  best_row_r, best_row_nxt;
  m3ws_pkg::pos_t  best_col_r, best_col_nxt;
  logic            found_r, found_nxt;

  // Line store and bypass
  logic [MAX_COLS_W-1:0] vld_r;
  logic [WB-1:0]   rd_data;
  logic [WB-1:0]   wr_data;
  logic            byp_r;
  logic [WB-1:0]   byp_data_r;
  logic [WB-1:0]   line_word;
  m3ws_pkg::cell_t a_cur, b_cur, new_cell;

  // Window
  m3ws_pkg::cell_t win_r [3][3];

  // Output register
  logic            out_valid_r;
  m3ws_pkg::sum_t  out_sum_r;
  m3ws_pkg::pos_t  out_row_r, out_col_r;
  logic            out_found_r;

  logic            in_acc, last_col, last_row, is_last, in_area, better;
  m3ws_pkg::sum_t  area_sum;

  // Sizes of zero act as one; sizes above the limit saturate.
  always_comb begin
    if (grid_rows_r == '0) begin
      rows_eff = SB'(1);
    end else if (grid_rows_r > SB'(m3ws_pkg::ROW_LIMIT)) begin
      rows_eff = SB'(m3ws_pkg::ROW_LIMIT);
    end else begin
      rows_eff = grid_rows_r;
    end
    if (grid_cols_r == '0) begin
      cols_eff = SB'(1);
    end else if (grid_cols_r > SB'(m3ws_pkg::MAX_COLS)) begin
      cols_eff = SB'(m3ws_pkg::MAX_COLS);
    end else begin
      cols_eff = grid_cols_r;
    end
  end

  assign last_col = (SB'(col_r) + SB'(1)) >= cols_eff;
  assign last_row = (SB'(row_r) + SB'(1)) >= rows_eff;
  assign is_last  = last_col && last_row;

  assign in_ch.ready = !(out_valid_r && !out_ch.ready && is_last);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign new_cell    = in_ch.cell_value;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (is_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + RB'(1);
      end else begin
        col_nxt = col_r + CB'(1);
      end
    end
  end

  // Word layout: upper half is the row above, lower half two rows above.
  always_comb begin
    if (byp_r) begin
      line_word = byp_data_r;
    end else if (vld_r[col_r]) begin
      line_word = rd_data;
    end else begin
      line_word = '0;
    end
  end

  assign a_cur   = line_word[WB-1:VB];
  assign b_cur   = line_word[VB-1:0];
  assign wr_data = {new_cell, a_cur};

  m3ws_ram #(
    .WIDTH (WB),
    .DEPTH (m3ws_pkg::MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_r),
    .wdata (wr_data),
    .raddr (col_nxt),
    .rdata (rd_data)
  );

  assign area_sum = m3ws_pkg::SUM_BITS'(win_r[0][1]) + m3ws_pkg::SUM_BITS'(win_r[0][2])
                  + m3ws_pkg::SUM_BITS'(win_r[1][1]) + m3ws_pkg::SUM_BITS'(win_r[1][2])
                  + m3ws_pkg::SUM_BITS'(win_r[2][1]) + m3ws_pkg::SUM_BITS'(win_r[2][2])
                  + m3ws_pkg::SUM_BITS'(b_cur) + m3ws_pkg::SUM_BITS'(a_cur)
                  + m3ws_pkg::SUM_BITS'(new_cell);

  assign in_area = (row_r >= RB'(2)) && (col_r >= CB'(2));
  assign better  = in_area && (area_sum > best_r);

  always_comb begin
    best_nxt     = best_r;
    best_row_nxt = best_row_r;
    best_col_nxt = best_col_r;
    found_nxt    = found_r;
    if (in_acc && better) begin
      best_nxt     = area_sum;
      best_row_nxt = m3ws_pkg::POS_BITS'(row_r - RB'(1));
      best_col_nxt = m3ws_pkg::POS_BITS'(col_r - CB'(1));
      found_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= SB'(10);
      grid_cols_r <= SB'(10);
      col_r       <= '0;
      row_r       <= '0;
      best_r      <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      found_r     <= 1'b0;
      vld_r       <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          m3ws_pkg::CFG_GRID_ROWS: grid_rows_r <= cfg_data;
          m3ws_pkg::CFG_GRID_COLS: grid_cols_r <= cfg_data;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      // The RAM misses a write to the column it is reading at the same edge.
      byp_r <= in_acc && (col_nxt == col_r);
      if (in_acc) begin
        vld_r[col_r] <= 1'b1;
      end
      if (in_acc && is_last) begin
        best_r      <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
        found_r     <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        best_r      <= best_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
        found_r     <= found_nxt;
        if (out_ch.ready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_data_r <= wr_data;
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= b_cur;
      win_r[1][2] <= a_cur;
      win_r[2][2] <= new_cell;
    end
    if (in_acc && is_last) begin
      out_sum_r   <= best_nxt;
      out_row_r   <= best_row_nxt;
      out_col_r   <= best_col_nxt;
      out_found_r <= found_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.best_sum   = out_sum_r;
  assign out_ch.center_row = out_row_r;
  assign out_ch.center_col = out_col_r;
  assign out_ch.found      = out_found_r;

  // A frame's last cell restarts the counters and the running best.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_last) |=> (col_r == '0 && row_r == '0 && !found_r && best_r == '0))
    else $error("frame state not cleared after last cell");

  // A pending result is never overwritten by the next frame's result.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && is_last) |-> !in_ch.ready)
    else $error("last cell accepted while result still pending");

  // The found flag and a positive best go together.
  a_found_best: assert property (@(posedge clk) disable iff (!rst_n)
    found_r == (best_r > 0))
    else $error("found flag disagrees with running best");

  // The bypass only fires when the column has not moved.
  a_bypass_col: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> (col_r == $past(col_r)))
    else $error("bypass active on a different column");

endmodule
